// ===== rtl/rcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_pkg
// shared types, codes and constants of the ring channel reader
// ----------------------------------------------------------------------------
package rcr_pkg;

    localparam int COUNTER_BITS = 64;
    localparam int EPOCH_BITS   = 64;
    localparam int WORD_BITS    = 64;
    localparam int SLOT_BITS    = 32;
    localparam int CFG_IDX_BITS = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_READER_PROTOCOL    = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EXPECTED_TRANSPORT = 1'd1;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_DRAIN = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_NO_DATA       = 3'd1,
        ST_OVERRUN       = 3'd2,
        ST_EPOCH_CHANGED = 3'd3,
        ST_INCOMPATIBLE  = 3'd4,
        ST_INACTIVE      = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_EVAL = 3'd1,
        S_DIV  = 3'd2,
        S_MUL  = 3'd3,
        S_FIN  = 3'd4,
        S_PUSH = 3'd5
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic eval;
        logic div_start;
        logic mul_load;
        logic fin;
        logic push;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/rcr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_in_if
// request channel: action plus a snapshot of the writer header
// ----------------------------------------------------------------------------
interface rcr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic        channel_active;
    logic [63:0] hdr_epoch;
    logic [63:0] hdr_epoch_after;
    logic [63:0] hdr_protocol;
    logic [63:0] hdr_transport;
    logic [31:0] hdr_size;
    logic [31:0] hdr_slots;
    logic [63:0] hdr_write_count;
    logic [63:0] hdr_write_start_count;

    modport source (
        output valid, action, channel_active, hdr_epoch, hdr_epoch_after,
               hdr_protocol, hdr_transport, hdr_size, hdr_slots,
               hdr_write_count, hdr_write_start_count,
        input  ready
    );
    modport sink (
        input  valid, action, channel_active, hdr_epoch, hdr_epoch_after,
               hdr_protocol, hdr_transport, hdr_size, hdr_slots,
               hdr_write_count, hdr_write_start_count,
        output ready
    );
endinterface

// ===== rtl/rcr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_out_if
// result channel: status, slot byte offset and pending flag
// ----------------------------------------------------------------------------
interface rcr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] element_offset;
    logic        pending;

    modport source (
        output valid, status, element_offset, pending,
        input  ready
    );
    modport sink (
        input  valid, status, element_offset, pending,
        output ready
    );
endinterface

// ===== rtl/rcr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_div
// restoring divider, one quotient bit a cycle, remainder only
// ----------------------------------------------------------------------------
module rcr_div #(
    parameter int DVD_BITS = rcr_pkg::COUNTER_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DVD_BITS-1:0]          i_dividend,
    input  logic [rcr_pkg::SLOT_BITS-1:0] i_divisor,
    output logic                         o_done,
    output logic [rcr_pkg::SLOT_BITS-1:0] o_rem
);
    localparam int CNT_BITS = $clog2(DVD_BITS + 1);
    localparam int SB       = rcr_pkg::SLOT_BITS;

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DVD_BITS-1:0] r_dvd;
    logic [SB-1:0]       r_rem;
    logic [SB-1:0]       r_dsr;
    logic [SB:0]         trial;
    logic [SB:0]         diff;
    logic                fits;

    assign trial = {r_rem, r_dvd[DVD_BITS-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign fits  = (trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_BITS'(DVD_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[SB-1:0] : trial[SB-1:0];
            r_dvd <= {r_dvd[DVD_BITS-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/rcr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_dp
// reader state, beat capture, decisions, slot offset and result register
// ----------------------------------------------------------------------------
module rcr_dp #(
    parameter int COUNTER_BITS = rcr_pkg::COUNTER_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [rcr_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [rcr_pkg::WORD_BITS-1:0]     i_cfg_wdata,
    // request payload
    input  logic [1:0]                        i_action,
    input  logic                              i_channel_active,
    input  logic [63:0]                       i_hdr_epoch,
    input  logic [63:0]                       i_hdr_epoch_after,
    input  logic [63:0]                       i_hdr_protocol,
    input  logic [63:0]                       i_hdr_transport,
    input  logic [31:0]                       i_hdr_size,
    input  logic [31:0]                       i_hdr_slots,
    input  logic [63:0]                       i_hdr_write_count,
    input  logic [63:0]                       i_hdr_write_start_count,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [2:0]                        o_status,
    output logic [63:0]                       o_element_offset,
    output logic                              o_pending,
    // control
    input  rcr_pkg::t_cmd                     i_cmd,
    output rcr_pkg::t_sts                     o_sts
);
    localparam int CB = COUNTER_BITS;
    localparam int SB = rcr_pkg::SLOT_BITS;
    localparam int EB = rcr_pkg::EPOCH_BITS;
    localparam int WB = rcr_pkg::WORD_BITS;

    // configuration registers
    logic [WB-1:0] r_cfg_protocol;
    logic [WB-1:0] r_cfg_transport;

    // reader state
    logic [EB-1:0] r_epoch;
    logic [SB-1:0] r_elem_size;
    logic [SB-1:0] r_slots;
    logic [CB-1:0] r_read_count;

    // captured beat
    rcr_pkg::t_action r_action;
    logic             r_active;
    logic [EB-1:0]    r_hdr_epoch;
    logic [EB-1:0]    r_hdr_epoch_after;
    logic [WB-1:0]    r_hdr_protocol;
    logic [WB-1:0]    r_hdr_transport;
    logic [SB-1:0]    r_hdr_size;
    logic [SB-1:0]    r_hdr_slots;
    logic [CB-1:0]    r_wc;
    logic [CB-1:0]    r_wsc;

    // result under construction and output register
    rcr_pkg::t_status r_res_status;
    logic [63:0]      r_res_offset;
    logic             r_res_pend;
    logic [63:0]      r_prod;
    logic             r_out_valid;
    rcr_pkg::t_status r_out_status;
    logic [63:0]      r_out_offset;
    logic             r_out_pend;

    // decisions
    logic          epoch_ok;
    logic          compat;
    logic [CB-1:0] slots_ext;
    logic [CB-1:0] fill;
    logic [CB-1:0] fill_start;
    logic          overrun;
    logic          overrun_start;
    logic          need_div;
    logic          div_done;
    logic [SB-1:0] rem;
    logic          out_free;

    assign epoch_ok      = (r_epoch != '0) && (r_epoch == r_hdr_epoch);
    assign compat        = (r_hdr_protocol == r_cfg_protocol)
                        && (r_hdr_transport == r_cfg_transport);
    assign slots_ext     = CB'(r_slots);
    assign fill          = r_wc - r_read_count;
    assign fill_start    = r_wsc - r_read_count;
    assign overrun       = (fill > slots_ext) || (r_slots == '0);
    assign overrun_start = (fill_start > slots_ext);
    assign need_div      = (r_action == rcr_pkg::ACT_READ) && r_active && epoch_ok
                        && (r_read_count != r_wc) && !overrun;
    assign out_free      = !r_out_valid || i_out_ready;

    rcr_div #(
        .DVD_BITS (CB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_read_count),
        .i_divisor  (r_slots),
        .o_done     (div_done),
        .o_rem      (rem)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_protocol  <= '0;
            r_cfg_transport <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rcr_pkg::CFG_READER_PROTOCOL:    r_cfg_protocol  <= i_cfg_wdata;
                rcr_pkg::CFG_EXPECTED_TRANSPORT: r_cfg_transport <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // reader state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch      <= '0;
            r_elem_size  <= '0;
            r_slots      <= '0;
            r_read_count <= '0;
        end else if (i_cmd.eval) begin
            case (r_action)
                rcr_pkg::ACT_READ, rcr_pkg::ACT_QUERY: begin
                    if (!r_active) begin
                        if (r_action == rcr_pkg::ACT_READ) begin
                            r_epoch <= '0;
                        end
                    end else if (!epoch_ok && compat) begin
                        r_epoch      <= r_hdr_epoch;
                        r_elem_size  <= r_hdr_size;
                        r_slots      <= r_hdr_slots;
                        r_read_count <= '0;
                    end
                end
                rcr_pkg::ACT_DRAIN: begin
                    r_read_count <= r_wc;
                end
                default: ;
            endcase
        end else if (i_cmd.fin) begin
            if (!overrun_start) begin
                r_read_count <= r_read_count + 1'b1;
            end
            if (r_hdr_epoch_after != r_epoch) begin
                r_epoch <= '0;
            end
        end
    end

    // beat capture, product and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action          <= rcr_pkg::t_action'(i_action);
            r_active          <= i_channel_active;
            r_hdr_epoch       <= i_hdr_epoch;
            r_hdr_epoch_after <= i_hdr_epoch_after;
            r_hdr_protocol    <= i_hdr_protocol;
            r_hdr_transport   <= i_hdr_transport;
            r_hdr_size        <= i_hdr_size;
            r_hdr_slots       <= i_hdr_slots;
            r_wc              <= i_hdr_write_count[CB-1:0];
            r_wsc             <= i_hdr_write_start_count[CB-1:0];
        end
        if (i_cmd.mul_load) begin
            r_prod <= 64'(rem) * 64'(r_elem_size);
        end
        if (i_cmd.eval) begin
            r_res_offset <= '0;
            r_res_pend   <= 1'b0;
            r_res_status <= rcr_pkg::ST_OK;
            case (r_action)
                rcr_pkg::ACT_READ: begin
                    if (!r_active) begin
                        r_res_status <= rcr_pkg::ST_INACTIVE;
                    end else if (!epoch_ok) begin
                        r_res_status <= compat ? rcr_pkg::ST_EPOCH_CHANGED
                                               : rcr_pkg::ST_INCOMPATIBLE;
                    end else if (r_read_count == r_wc) begin
                        r_res_status <= rcr_pkg::ST_NO_DATA;
                    end else begin
                        r_res_status <= rcr_pkg::ST_OVERRUN;
                    end
                end
                rcr_pkg::ACT_QUERY: begin
                    if (!r_active) begin
                        r_res_status <= rcr_pkg::ST_INACTIVE;
                    end else if (!epoch_ok) begin
                        if (compat) begin
                            r_res_status <= rcr_pkg::ST_EPOCH_CHANGED;
                            // count restarts at zero on resync
                            r_res_pend   <= (r_wc != '0);
                        end else begin
                            r_res_status <= rcr_pkg::ST_INCOMPATIBLE;
                        end
                    end else begin
                        r_res_pend <= (r_wc > r_read_count);
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.fin) begin
            r_res_offset <= r_prod;
            r_res_pend   <= 1'b0;
            if (r_hdr_epoch_after != r_epoch) begin
                r_res_status <= rcr_pkg::ST_EPOCH_CHANGED;
            end else if (overrun_start) begin
                r_res_status <= rcr_pkg::ST_OVERRUN;
            end else begin
                r_res_status <= rcr_pkg::ST_OK;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && out_free) begin
            r_out_status <= r_res_status;
            r_out_offset <= r_res_offset;
            r_out_pend   <= r_res_pend;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_element_offset = r_out_offset;
    assign o_pending        = r_out_pend;

    assign o_sts.need_div = need_div;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = out_free;

endmodule

// ===== rtl/rcr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_ctrl
// sequencer: capture, decide, divide, multiply, finish, hand over
// ----------------------------------------------------------------------------
module rcr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rcr_pkg::t_sts i_sts,
    output rcr_pkg::t_cmd o_cmd
);
    rcr_pkg::t_state r_state;
    rcr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rcr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = rcr_pkg::S_EVAL;
                end
            end
            rcr_pkg::S_EVAL: begin
                if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = rcr_pkg::S_DIV;
                end else begin
                    o_cmd.eval = 1'b1;
                    n_state    = rcr_pkg::S_PUSH;
                end
            end
            rcr_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = rcr_pkg::S_MUL;
                end
            end
            rcr_pkg::S_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = rcr_pkg::S_FIN;
            end
            rcr_pkg::S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = rcr_pkg::S_PUSH;
            end
            rcr_pkg::S_PUSH: begin
                o_cmd.push = 1'b1;
                if (i_sts.out_free) begin
                    n_state = rcr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rcr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ring_channel_reader_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_channel_reader_top
// consumer side of a shared-memory ring channel: epoch tracking, resync,
// overrun detection and the byte offset of the next slot to copy
// ----------------------------------------------------------------------------
//  channel   | dir | handshake         | beat contents
//  ----------+-----+-------------------+-------------------------------------
//  i_item    | in  | valid / ready     | action, active flag, header snapshot
//  o_result  | out | valid / ready     | status, element_offset, pending
//  i_cfg_*   | in  | write enable only | reader_protocol, expected_transport
//
//  a beat passes accept, decide and hand over unless it is a read that
//  reaches the copy stage; that one also passes divide, multiply and finish,
//  the divide step being the bit-serial remainder of read count by slot count
//  one beat in flight at a time; the next is taken as soon as the result is
//  parked in the output register, even while that register waits on ready
//  synchronous active-low reset clears the reader state and configuration
// ----------------------------------------------------------------------------
module ring_channel_reader_top #(
    parameter int COUNTER_BITS = rcr_pkg::COUNTER_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rcr_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [rcr_pkg::WORD_BITS-1:0]    i_cfg_wdata,
    rcr_in_if.sink                           i_item,
    rcr_out_if.source                        o_result
);
    // command and status between sequencer and datapath
    rcr_pkg::t_cmd cmd;
    rcr_pkg::t_sts sts;

    // sequencer owns the request ready; datapath owns everything else
    rcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rcr_dp #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_idx               (i_cfg_idx),
        .i_cfg_wdata             (i_cfg_wdata),
        .i_action                (i_item.action),
        .i_channel_active        (i_item.channel_active),
        .i_hdr_epoch             (i_item.hdr_epoch),
        .i_hdr_epoch_after       (i_item.hdr_epoch_after),
        .i_hdr_protocol          (i_item.hdr_protocol),
        .i_hdr_transport         (i_item.hdr_transport),
        .i_hdr_size              (i_item.hdr_size),
        .i_hdr_slots             (i_item.hdr_slots),
        .i_hdr_write_count       (i_item.hdr_write_count),
        .i_hdr_write_start_count (i_item.hdr_write_start_count),
        // result register drives the outgoing channel directly
        .o_out_valid             (o_result.valid),
        .i_out_ready             (o_result.ready),
        .o_status                (o_result.status),
        .o_element_offset        (o_result.element_offset),
        .o_pending               (o_result.pending),
        .i_cmd                   (cmd),
        .o_sts                   (sts)
    );

endmodule

// ===== rtl/rcr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_checker
// port-level checks of the ring channel reader, bound to the top level
// ----------------------------------------------------------------------------
module rcr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_status,
    input  logic [63:0] i_element_offset,
    input  logic        i_pending
);
    // result beat held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped before it was taken");

    // one beat at a time: no new request right after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous still in work");

    // pending answer only on a clean or resynced query
    a_pending_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_pending |->
            (i_status == rcr_pkg::ST_OK) || (i_status == rcr_pkg::ST_EPOCH_CHANGED))
        else $error("pending flag with a failing status");

    // a slot offset only comes from a read that reached the copy stage
    a_offset_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_element_offset != '0) |->
            (i_status == rcr_pkg::ST_OK) || (i_status == rcr_pkg::ST_OVERRUN)
            || (i_status == rcr_pkg::ST_EPOCH_CHANGED))
        else $error("slot offset with a status that never copies");

endmodule

bind ring_channel_reader_top rcr_checker u_rcr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_item.valid),
    .i_in_ready       (i_item.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_status         (o_result.status),
    .i_element_offset (o_result.element_offset),
    .i_pending        (o_result.pending)
);
